// ----- hdl/jts_pkg.sv -----
package jts_pkg;

  localparam int TimerCountDefault = 16;
  localparam logic [15:0] SliceReset = 16'd100;
  localparam logic [31:0] GenSeed = 32'h2545_F491;

  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_STOP = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic KIND_FIRED  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [63:0] expiry;
    logic [63:0] period;
    logic [6:0]  jitter;
    logic [31:0] rnd;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SET_RD,
    S_CALC,
    S_DISARM,
    S_SCAN,
    S_DRAIN,
    S_PICK,
    S_OUT_FIRE,
    S_OUT_STAT
  } top_state_e;

  typedef enum logic [2:0] {
    EC_IDLE,
    EC_QDIV,
    EC_RDIV,
    EC_MUL,
    EC_TDIV,
    EC_ADD,
    EC_MDIV,
    EC_FIN
  } calc_state_e;

  // xorshift32 with shifts 13, 17, 5
  function automatic logic [31:0] xorshift(input logic [31:0] s);
    logic [31:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

// ----- hdl/jts_expiry_calc.sv -----
module jts_expiry_calc import jts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] rnd_i,
  input  logic [6:0]  pct_i,
  input  logic [63:0] rel_i,
  input  logic [63:0] now_i,
  input  logic [15:0] slice_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] expiry_o
);

  // ceil(2^22 / 100), exact for dividends below 2^15
  localparam logic [15:0] Recip100 = 16'd41944;

  calc_state_e st_q, st_d;
  logic [71:0] num_q;
  logic [31:0] rem_q, div_q, rnd_q;
  logic [6:0]  cnt_q, r_q;
  logic [63:0] rel_q, now_q, c_q, res_q;
  logic [15:0] slice_q;

  logic [32:0] rem_sh;
  logic        ge, last_step;
  logic [31:0] rem_nx;
  logic [71:0] num_nx;
  logic [64:0] sum, fin_sum;
  logic [63:0] c2;
  logic [70:0] prod;
  logic [14:0] dv, dq_sub, dr;
  logic [30:0] dq_prod;
  logic [7:0]  dq;
  logic [71:0] tq_nx;

  // one restoring divider step per cycle
  assign rem_sh    = {rem_q, num_q[71]};
  assign ge        = rem_sh >= {1'b0, div_q};
  assign rem_nx    = ge ? 32'(rem_sh - {1'b0, div_q}) : rem_sh[31:0];
  assign num_nx    = {num_q[70:0], ge};
  assign last_step = cnt_q == 7'd1;

  // divide by 100 one byte a cycle, remainder stays below 100
  assign dv      = {rem_q[6:0], num_q[71:64]};
  assign dq_prod = 31'(dv) * 31'(Recip100);
  assign dq      = dq_prod[29:22];
  assign dq_sub  = 15'(dq) * 15'd100;
  assign dr      = dv - dq_sub;
  assign tq_nx   = {num_q[63:0], dq};

  assign sum     = {1'b0, now_q} + {1'b0, rel_q};
  assign c2      = c_q - {48'd0, rem_nx[15:0]};
  assign fin_sum = {1'b0, c2} + {49'd0, slice_q};
  assign prod    = 71'(r_q) * 71'(rel_q);

  always_comb begin
    st_d = st_q;
    case (st_q)
      EC_IDLE: if (start_i) st_d = (pct_i != 7'd0) ? EC_QDIV : EC_ADD;
      EC_QDIV: if (last_step) st_d = EC_RDIV;
      EC_RDIV: if (last_step) st_d = (num_nx[31:0] >= 32'd100) ? EC_ADD : EC_MUL;
      EC_MUL:  st_d = EC_TDIV;
      EC_TDIV: if (last_step) st_d = EC_ADD;
      EC_ADD:  st_d = sum[64] ? EC_FIN : EC_MDIV;
      EC_MDIV: if (last_step) st_d = EC_FIN;
      EC_FIN:  st_d = EC_IDLE;
      default: st_d = EC_IDLE;
    endcase
  end

  always_comb begin
    busy_o   = st_q != EC_IDLE;
    done_o   = st_q == EC_FIN;
    expiry_o = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= EC_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      EC_IDLE: begin
        if (start_i) begin
          rnd_q   <= rnd_i;
          rel_q   <= rel_i;
          now_q   <= now_i;
          slice_q <= (slice_i == 16'd0) ? 16'd1 : slice_i;
          num_q   <= {32'hFFFF_FFFF, 40'd0};
          div_q   <= {25'd0, pct_i};
          rem_q   <= '0;
          cnt_q   <= 7'd32;
        end
      end
      EC_QDIV: begin
        if (last_step) begin
          num_q <= {rnd_q, 40'd0};
          div_q <= num_nx[31:0];
          rem_q <= '0;
          cnt_q <= 7'd32;
        end else begin
          num_q <= num_nx;
          rem_q <= rem_nx;
          cnt_q <= cnt_q - 7'd1;
        end
      end
      EC_RDIV: begin
        if (last_step) begin
          if (num_nx[31:0] >= 32'd100) rel_q <= '0;
          else r_q <= num_nx[6:0];
        end else begin
          num_q <= num_nx;
          rem_q <= rem_nx;
          cnt_q <= cnt_q - 7'd1;
        end
      end
      EC_MUL: begin
        num_q <= {1'b0, prod};
        rem_q <= '0;
        cnt_q <= 7'd9;
      end
      EC_TDIV: begin
        if (last_step) begin
          rel_q <= rel_q - tq_nx[63:0];
        end else begin
          num_q <= tq_nx;
          rem_q <= {25'd0, dr[6:0]};
          cnt_q <= cnt_q - 7'd1;
        end
      end
      EC_ADD: begin
        if (sum[64]) begin
          res_q <= '1;
        end else begin
          c_q   <= sum[63:0];
          num_q <= {sum[63:0], 8'd0};
          div_q <= {16'd0, slice_q};
          rem_q <= '0;
          cnt_q <= 7'd64;
        end
      end
      EC_MDIV: begin
        if (last_step) begin
          res_q <= fin_sum[64] ? '1 : fin_sum[63:0];
        end else begin
          num_q <= num_nx;
          rem_q <= rem_nx;
          cnt_q <= cnt_q - 7'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/jittered_timer_scheduler.sv -----
// Timer table with jittered expiry, one item in flight at a time.
// Input channel (in_valid_i / in_stall_o) carries set, stop and tick items;
// output channel (out_valid_o / out_stall_i) returns zero or more fired
// items followed by one status item with last_o set. cfg_we_i writes the
// time slice; the user must write it only while the block is idle, which
// the block itself does not enforce. A pass over the table reads one slot
// a cycle. A set, stop or unused operation ends with one pass and its
// status item; a stop with a valid index first disarms its slot. A set
// with a nonzero first delay also runs the expiry unit: with jitter, at
// most two 32-step divides, a 9-step divide by 100 and a 64-step rounding
// divide; without jitter, at most the rounding divide. A tick makes one
// pass per fired timer plus two more, each fire adding its output
// handshake and a disarm or a re-arm through the expiry unit. After the
// status item is taken, out_valid_q clears and the state returns to idle
// before the next item is accepted; in_stall_o stays high from acceptance
// until then, so a stalled receiver holds the whole block.
// Reset disarms all timers, reloads the generator seed and sets the time
// slice to 100; the table memory needs no clearing.
module jittered_timer_scheduler import jts_pkg::*; #(
  parameter int TIMER_COUNT = TimerCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  timer_index_i,
  input  logic [63:0] first_delay_i,
  input  logic [63:0] interval_i,
  input  logic        periodic_i,
  input  logic [6:0]  jitter_percent_i,
  input  logic [63:0] now_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        item_kind_o,
  output logic [3:0]  fired_index_o,
  output logic [63:0] fired_time_o,
  output logic [63:0] next_expiry_o,
  output logic        last_o
);

  localparam int IW = $clog2(TIMER_COUNT);
  localparam logic [IW-1:0] LastSlot = IW'(TIMER_COUNT - 1);

  top_state_e st_q, st_d;

  entry_t mem [TIMER_COUNT];
  entry_t rdata_q, best_q, wdata;
  logic          mem_re, mem_we;
  logic [IW-1:0] raddr;

  logic [1:0]  op_q;
  logic [3:0]  idx_q;
  logic [63:0] first_q, ival_q, now_q;
  logic        per_q;
  logic [6:0]  pct_q;
  logic [15:0] slice_q;
  logic [31:0] gen_q, gen_next;
  logic [IW-1:0] tgt_q, scan_q, cmp_idx_q, best_idx_q;
  logic        tick_q, status_q, cmp_vld_q, found_q;
  logic [TIMER_COUNT-1:0] armed_q, done_q;
  logic [63:0] wr_period_q;
  logic [6:0]  wr_jitter_q;
  logic [31:0] rnd_q;

  logic        out_valid_q, kind_q, last_q;
  logic [3:0]  fidx_q;
  logic [63:0] ftime_q, next_q;

  logic        idx_ok, expired, better, out_take, leave_fire;
  logic        calc_start, calc_busy, calc_done;
  logic [31:0] calc_rnd;
  logic [6:0]  calc_pct;
  logic [63:0] calc_rel, calc_exp;

  assign idx_ok     = 32'(idx_q) < 32'(TIMER_COUNT);
  assign expired    = best_q.expiry <= now_q;
  assign gen_next   = xorshift(gen_q);
  assign out_take   = out_valid_q && !out_stall_i;
  assign leave_fire = (st_q == S_OUT_FIRE) && !out_valid_q;
  // in a tick's fire-search passes, slots already fired are skipped
  assign better     = cmp_vld_q && armed_q[cmp_idx_q]
                      && !(!status_q && done_q[cmp_idx_q])
                      && (!found_q || rdata_q.expiry < best_q.expiry);

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE:   if (in_valid_i) st_d = S_DECODE;
      S_DECODE: begin
        if (op_q == OP_SET && idx_ok) st_d = (first_q == 64'd0) ? S_DISARM : S_SET_RD;
        else if (op_q == OP_STOP && idx_ok) st_d = S_DISARM;
        else st_d = S_SCAN;
      end
      S_SET_RD: st_d = S_CALC;
      S_CALC:   if (calc_done) st_d = S_SCAN;
      S_DISARM: st_d = S_SCAN;
      S_SCAN:   if (scan_q == LastSlot) st_d = S_DRAIN;
      S_DRAIN:  st_d = S_PICK;
      S_PICK: begin
        if (status_q) st_d = S_OUT_STAT;
        else if (found_q && expired) st_d = S_OUT_FIRE;
        else st_d = S_SCAN;
      end
      S_OUT_FIRE: if (!out_valid_q) st_d = (best_q.period == 64'd0) ? S_DISARM : S_CALC;
      S_OUT_STAT: if (!out_valid_q) st_d = S_IDLE;
      default:  st_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = st_q != S_IDLE;
    mem_re     = (st_q == S_DECODE) || (st_q == S_SCAN);
    raddr      = (st_q == S_DECODE) ? tgt_q : scan_q;
    mem_we     = (st_q == S_CALC) && calc_done;
    wdata      = '{expiry: calc_exp, period: wr_period_q, jitter: wr_jitter_q, rnd: rnd_q};
    calc_start = (st_q == S_SET_RD) || (leave_fire && best_q.period != 64'd0);
    if (st_q == S_SET_RD) begin
      calc_rnd = armed_q[tgt_q] ? rdata_q.rnd : gen_next;
      calc_pct = pct_q;
      calc_rel = first_q;
    end else begin
      calc_rnd = gen_next;
      calc_pct = best_q.jitter;
      calc_rel = best_q.period;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[tgt_q] <= wdata;
    if (mem_re) rdata_q <= mem[raddr];
  end

  jts_expiry_calc u_calc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (calc_start),
    .rnd_i    (calc_rnd),
    .pct_i    (calc_pct),
    .rel_i    (calc_rel),
    .now_i    (now_q),
    .slice_i  (slice_q),
    .busy_o   (calc_busy),
    .done_o   (calc_done),
    .expiry_o (calc_exp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      slice_q     <= SliceReset;
      gen_q       <= GenSeed;
      armed_q     <= '0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      tick_q      <= 1'b0;
      status_q    <= 1'b0;
      scan_q      <= '0;
    end else begin
      st_q      <= st_d;
      cmp_vld_q <= st_q == S_SCAN;
      if (cfg_we_i) slice_q <= cfg_wdata_i;
      if (st_q == S_IDLE && in_valid_i) tick_q <= operation_i == OP_TICK;
      if (st_q == S_DECODE) done_q <= '0;
      if (calc_start && !(st_q == S_SET_RD && armed_q[tgt_q])) gen_q <= gen_next;
      if (mem_we) armed_q[tgt_q] <= 1'b1;
      if (st_q == S_DISARM) armed_q[tgt_q] <= 1'b0;
      if (st_d == S_SCAN && st_q != S_SCAN) begin
        scan_q   <= '0;
        found_q  <= 1'b0;
        status_q <= !tick_q || (st_q == S_PICK);
      end else if (st_q == S_SCAN) begin
        scan_q <= scan_q + IW'(1);
      end
      if (better) found_q <= 1'b1;
      if (st_q == S_PICK && st_d == S_OUT_FIRE) done_q[best_idx_q] <= 1'b1;
      if (st_q == S_PICK && (st_d == S_OUT_FIRE || st_d == S_OUT_STAT)) out_valid_q <= 1'b1;
      else if (out_take) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && in_valid_i) begin
      op_q    <= operation_i;
      idx_q   <= timer_index_i;
      tgt_q   <= IW'(timer_index_i);
      first_q <= first_delay_i;
      ival_q  <= interval_i;
      per_q   <= periodic_i;
      pct_q   <= jitter_percent_i;
      now_q   <= now_time_i;
    end
    cmp_idx_q <= scan_q;
    if (better) begin
      best_q     <= rdata_q;
      best_idx_q <= cmp_idx_q;
    end
    if (st_q == S_SET_RD) begin
      rnd_q       <= calc_rnd;
      wr_period_q <= per_q ? ival_q : 64'd0;
      wr_jitter_q <= pct_q;
    end else if (calc_start) begin
      rnd_q       <= calc_rnd;
      wr_period_q <= best_q.period;
      wr_jitter_q <= best_q.jitter;
    end
    if (st_q == S_PICK) begin
      if (st_d == S_OUT_FIRE) begin
        tgt_q   <= best_idx_q;
        kind_q  <= KIND_FIRED;
        fidx_q  <= 4'(best_idx_q);
        ftime_q <= best_q.expiry;
        next_q  <= '0;
        last_q  <= 1'b0;
      end else begin
        kind_q  <= KIND_STATUS;
        fidx_q  <= '0;
        ftime_q <= '0;
        next_q  <= found_q ? best_q.expiry : '1;
        last_q  <= 1'b1;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign item_kind_o   = kind_q;
  assign fired_index_o = fidx_q;
  assign fired_time_o  = ftime_q;
  assign next_expiry_o = next_q;
  assign last_o        = last_q;

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> st_q == S_DECODE)
    else $error("accepted item not decoded");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_IDLE |-> !out_valid_q)
    else $error("result pending while idle");

  a_fired_expired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o == KIND_FIRED |-> fired_time_o <= now_q)
    else $error("timer fired before its expiry");

  a_calc_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calc_busy |-> st_q == S_CALC)
    else $error("expiry unit busy outside calc state");

endmodule

// ----- verif/jts_checker.sv -----
module jts_checker import jts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  timer_index_i,
  input  logic [63:0] first_delay_i,
  input  logic [63:0] interval_i,
  input  logic        periodic_i,
  input  logic [6:0]  jitter_percent_i,
  input  logic [63:0] now_time_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic        item_kind_o,
  input  logic [3:0]  fired_index_o,
  input  logic [63:0] fired_time_o,
  input  logic [63:0] next_expiry_o,
  input  logic        last_o,
  output int          errors_o,
  output int          pending_o
);

  localparam int Slots = 16;
  localparam logic [63:0] NonePending = '1;

  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    logic [63:0] fired_at;
    logic [63:0] next_due;
    logic        last;
  } timer_result_t;

  logic [15:0] slice_q;
  logic        armed_q [Slots];
  logic [63:0] due_q [Slots];
  logic [63:0] period_q [Slots];
  logic [6:0]  pct_q [Slots];
  logic [31:0] word_q [Slots];
  logic [31:0] lfsr_q;
  timer_result_t due_results_q[$];

  function automatic logic [31:0] next_word();
    logic [31:0] x;
    x = lfsr_q;
    x ^= x << 13;
    x ^= x >> 17;
    x ^= x << 5;
    lfsr_q = x;
    return x;
  endfunction

  function automatic logic [63:0] jittered_due(logic [31:0] rnd, logic [6:0] pct,
                                                logic [63:0] delay, logic [63:0] now_v);
    logic [63:0] sl, rel, c, r, cut;
    logic [31:0] q;
    sl = (slice_q == 0) ? 64'd1 : {48'd0, slice_q};
    rel = delay;
    if (pct != 0) begin
      q = 32'hFFFF_FFFF / {25'd0, pct};
      r = {32'd0, rnd / q};
      if (r >= 100) cut = rel;
      else cut = r * (rel / 100) + (r * (rel % 100)) / 100;
      rel = rel - cut;
    end
    if (rel > ~now_v) return NonePending;
    c = now_v + rel;
    c = c - c % sl;
    if (c > NonePending - sl) return NonePending;
    return c + sl;
  endfunction

  function automatic int soonest(logic skip [Slots]);
    int best;
    best = -1;
    for (int i = 0; i < Slots; i++) begin
      if (armed_q[i] && !skip[i] && (best < 0 || due_q[i] < due_q[best])) best = i;
    end
    return best;
  endfunction

  function automatic void disarm(int i);
    if (armed_q[i]) begin
      armed_q[i] = 1'b0;
      word_q[i] = '0;
    end
  endfunction

  task automatic predict_item();
    logic fired [Slots];
    logic none [Slots];
    int t;
    timer_result_t res;
    for (int i = 0; i < Slots; i++) begin
      fired[i] = 1'b0;
      none[i] = 1'b0;
    end
    if (operation_i == OP_SET) begin
      if (first_delay_i == 0) begin
        disarm(timer_index_i);
      end else begin
        pct_q[timer_index_i] = jitter_percent_i;
        if (word_q[timer_index_i] == 0) word_q[timer_index_i] = next_word();
        due_q[timer_index_i] = jittered_due(word_q[timer_index_i], jitter_percent_i,
                                            first_delay_i, now_time_i);
        period_q[timer_index_i] = periodic_i ? interval_i : 64'd0;
        armed_q[timer_index_i] = 1'b1;
      end
    end else if (operation_i == OP_STOP) begin
      disarm(timer_index_i);
    end else if (operation_i == OP_TICK) begin
      forever begin
        t = soonest(fired);
        if (t < 0 || due_q[t] > now_time_i) break;
        fired[t] = 1'b1;
        res = '{KIND_FIRED, t[3:0], due_q[t], 64'd0, 1'b0};
        due_results_q.push_back(res);
        if (period_q[t] == 0) begin
          disarm(t);
        end else begin
          word_q[t] = next_word();
          due_q[t] = jittered_due(word_q[t], pct_q[t], period_q[t], now_time_i);
        end
      end
    end
    t = soonest(none);
    res = '{KIND_STATUS, 4'd0, 64'd0, (t < 0) ? NonePending : due_q[t], 1'b1};
    due_results_q.push_back(res);
  endtask

  task automatic compare_result();
    timer_result_t exp_r;
    if (due_results_q.size() == 0) begin
      $display("%0t: unexpected item kind=%0d idx=%0d", $time, item_kind_o, fired_index_o);
      errors_o++;
    end else begin
      exp_r = due_results_q.pop_front();
      if (item_kind_o !== exp_r.kind || fired_index_o !== exp_r.slot ||
          fired_time_o !== exp_r.fired_at || next_expiry_o !== exp_r.next_due ||
          last_o !== exp_r.last) begin
        $display("%0t: mismatch expected kind=%0d idx=%0d fired=%0h next=%0h last=%0d",
                 $time, exp_r.kind, exp_r.slot, exp_r.fired_at, exp_r.next_due, exp_r.last);
        $display("%0t:          actual   kind=%0d idx=%0d fired=%0h next=%0h last=%0d",
                 $time, item_kind_o, fired_index_o, fired_time_o, next_expiry_o, last_o);
        errors_o++;
      end
    end
  endtask

  initial begin
    errors_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q = SliceReset;
      lfsr_q = GenSeed;
      for (int i = 0; i < Slots; i++) begin
        armed_q[i] = 1'b0;
        due_q[i] = '0;
        period_q[i] = '0;
        pct_q[i] = '0;
        word_q[i] = '0;
      end
      due_results_q.delete();
    end else begin
      if (cfg_we_i) slice_q = cfg_wdata_i;
      if (out_valid_o && !out_stall_i) compare_result();
      if (in_valid_i && !in_stall_o) predict_item();
    end
    pending_o = due_results_q.size();
  end

endmodule

// ----- verif/testbench.sv -----
module testbench import jts_pkg::*;;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int WatchdogLimit = 40000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = OP_TICK;
  logic [3:0]  timer_index_i = '0;
  logic [63:0] first_delay_i = '0;
  logic [63:0] interval_i = '0;
  logic        periodic_i = 1'b0;
  logic [6:0]  jitter_percent_i = '0;
  logic [63:0] now_time_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        item_kind_o;
  logic [3:0]  fired_index_o;
  logic [63:0] fired_time_o;
  logic [63:0] next_expiry_o;
  logic        last_o;
  int          errors;
  int          pending;

  logic        calm = 1'b0;
  logic        hold_req = 1'b0;
  logic [63:0] now_cur = '0;
  int          cur_slice = 100;

  jittered_timer_scheduler dut (.*);

  jts_checker checker_i (.*, .errors_o(errors), .pending_o(pending));

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver side
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send(logic [1:0] op, logic [3:0] idx, logic [63:0] delay,
                      logic [63:0] ival, logic per, logic [6:0] pct, logic [63:0] now_v);
    in_valid_i <= 1'b1;
    operation_i <= op;
    timer_index_i <= idx;
    first_delay_i <= delay;
    interval_i <= ival;
    periodic_i <= per;
    jitter_percent_i <= pct;
    now_time_i <= now_v;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_slice(int v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[15:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_slice = v;
  endtask

  function automatic logic [63:0] span(int sl);
    case ($urandom_range(0, 11))
      0: return 64'd0;
      1: return {$urandom, $urandom};
      default: return 64'($urandom_range(1, 4 * sl));
    endcase
  endfunction

  task automatic random_item();
    int sl;
    int pick;
    logic [6:0] pct;
    sl = (cur_slice == 0) ? 1 : cur_slice;
    pick = $urandom_range(0, 99);
    pct = ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(0, 100));
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    if (pick < 2) now_cur = {$urandom, $urandom};
    else if (pick < 4) now_cur = 64'($urandom_range(0, 1000));
    if (pick < 40) begin
      send(OP_SET, 4'($urandom_range(0, 15)), span(sl), span(sl), 1'($urandom),
           pct, now_cur);
    end else if (pick < 55) begin
      send(OP_STOP, 4'($urandom_range(0, 15)), {$urandom, $urandom}, {$urandom, $urandom},
           1'($urandom), 7'($urandom), now_cur);
    end else if (pick < 58) begin
      send(OpUnused, 4'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
           1'($urandom), 7'($urandom), now_cur);
    end else begin
      now_cur = now_cur + 64'($urandom_range(0, 3 * sl));
      send(OP_TICK, 4'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
           1'($urandom), 7'($urandom), now_cur);
    end
  endtask

  initial begin
    int slices [6];
    slices = '{100, 1, 65535, 0, 37, 250};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every operation, jitter, ties, saturation
    send(OP_SET, 4'd0, 64'd1, 64'd0, 1'b0, 7'd0, 64'd0);
    send(OP_SET, 4'd15, '1, '1, 1'b1, 7'd100, 64'd0);
    send(OP_SET, 4'd3, 64'd250, 64'd250, 1'b1, 7'd50, 64'd0);
    send(OP_SET, 4'd4, 64'd150, 64'd0, 1'b0, 7'd0, 64'd0);
    send(OP_SET, 4'd5, 64'd150, 64'd0, 1'b1, 7'd0, 64'd0);
    send(OP_STOP, 4'd7, 64'd0, 64'd0, 1'b0, 7'd0, 64'd0);
    send(OpUnused, 4'd2, '1, '1, 1'b1, 7'h7f, '1);
    send(OP_TICK, 4'd0, 64'd0, 64'd0, 1'b0, 7'd0, 64'd99);
    send(OP_TICK, 4'd0, 64'd0, 64'd0, 1'b0, 7'd0, 64'd200);
    send(OP_SET, 4'd3, 64'd0, 64'd0, 1'b0, 7'd0, 64'd200);
    send(OP_SET, 4'd8, 64'd5, 64'd1, 1'b1, 7'd1, 64'hFFFF_FFFF_FFFF_FF00);
    send(OP_SET, 4'd9, '1, 64'd10, 1'b1, 7'd0, 64'd1000);
    send(OP_TICK, 4'd0, 64'd0, 64'd0, 1'b0, 7'd0, 64'd1000);
    send(OP_TICK, 4'd0, 64'd0, 64'd0, 1'b0, 7'd0, '1);
    send(OP_STOP, 4'd15, 64'd0, 64'd0, 1'b0, 7'd0, '1);
    send(OP_SET, 4'd10, 64'd1000, 64'd1000, 1'b1, 7'd99, 64'd5000);
    send(OP_SET, 4'd11, 64'd1000, 64'd0, 1'b1, 7'd100, 64'd5000);
    send(OP_TICK, 4'd0, 64'd0, 64'd0, 1'b0, 7'd0, 64'd7000);
    for (int i = 0; i < 16; i++) begin
      if (i == 0) write_slice(65535);
    end

    for (int p = 0; p < 6; p++) begin
      if (p > 0) write_slice(slices[p]);
      if (p == 5) calm = 1'b1;
      for (int n = 0; n < 45; n++) begin
        if (p == 1 && n == 10) hold_req = 1'b1;
        random_item();
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
